// ===== sv/lss_pkg.sv =====
// shared types and constants for the least-squares slope block
`timescale 1ns / 1ps
package lss_pkg;

  localparam int XW      = 24;   // x_value / y_value width
  localparam int SLOPE_W = 32;
  localparam int CNT_W   = 13;
  localparam int SUM1_W  = 36;   // sum_x, sum_y
  localparam int SUM2_W  = 60;   // sum_xy, sum_xx
  localparam int MA_W    = 37;   // shared multiplier, wide operand
  localparam int MB_W    = 25;   // shared multiplier, narrow operand
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 74;   // numerator / denominator
  localparam int DIV_STEPS = 32;
  localparam int STEP_W  = 5;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  // final product sequence: bit 2 picks numerator or denominator, low bits the term
  localparam logic [2:0] FIN_LAST = 3'd7;
  localparam logic [1:0] TERM_N_LO = 2'd0;  // count * wide sum, low part
  localparam logic [1:0] TERM_N_HI = 2'd1;  // count * wide sum, high part
  localparam logic [1:0] TERM_S_LO = 2'd2;  // sum_x * narrow sum, low part
  localparam logic [1:0] TERM_S_HI = 2'd3;  // sum_x * narrow sum, high part

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEN_ZERO = 2'd1,
    ST_SAT      = 2'd2,
    ST_OVERFLOW = 2'd3
  } lss_status_t;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_XY   = 2'd1,
    MUL_XX   = 2'd2,
    MUL_FIN  = 2'd3
  } lss_mul_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XY,
    S_XX,
    S_MUL,
    S_DRAIN,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } lss_state_t;

  typedef struct packed {
    lss_mul_op_t mul_op;
    logic [2:0]  fin_step;
    logic        load_in;
    logic        div_init;
    logic        div_step;
    logic        load_out;
  } lss_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } lss_stat_t;

endpackage

// ===== sv/lss_pt_if.sv =====
// point channel: valid/ready with x, y and last flag
`timescale 1ns / 1ps
interface lss_pt_if;
  logic                         valid;
  logic                         ready;
  logic signed [lss_pkg::XW-1:0] x_value;
  logic signed [lss_pkg::XW-1:0] y_value;
  logic                         last_point;

  modport source (output valid, output x_value, output y_value, output last_point,
                  input ready);
  modport sink (input valid, input x_value, input y_value, input last_point,
                output ready);
endinterface

// ===== sv/lss_res_if.sv =====
// result channel: valid/ready with slope, status and point count
`timescale 1ns / 1ps
interface lss_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [lss_pkg::SLOPE_W-1:0] slope;
  logic [1:0]                        status;
  logic [lss_pkg::CNT_W-1:0]         point_count;

  modport source (output valid, output slope, output status, output point_count,
                  input ready);
  modport sink (input valid, input slope, input status, input point_count,
                output ready);
endinterface

// ===== sv/least_squares_slope_core.sv =====
// top level of the least-squares slope block
`timescale 1ns / 1ps
// usage:
//   points: one (x_value, y_value) pair per beat, signed Q8.16, last_point set
//     on the final point of a set. result: one beat per set carrying the slope
//     (Q16.16, truncated toward zero, saturated), status and point_count.
//   sharing: the 24x24 products x*y and x*x of a point share one multiplier, in
//     states S_XY and S_XX, and the next point is taken in S_XX.
//   after the last point is taken: its products in S_XY and S_XX, then S_MUL
//     runs n*Sxy, Sx*Sy, n*Sxx and Sx*Sx through the shared 37x25 multiplier,
//     S_DRAIN does the last accumulate, S_DIV_INIT sets up and S_DIV runs the
//     one-bit-per-cycle divider, and S_DONE loads the result register, from
//     which the result beat shows. No point is taken during that time.
//   stall: the result register holds its beat while result.ready is low; the
//     sums are cleared when the beat is loaded, so points of the next set are
//     taken while the previous result still waits. A set that finishes while a
//     result is still waiting holds until the register frees.
//   points beyond MAX_POINTS are dropped and the set reports too many points.
//   reset: clears the sums, the count and the result valid flag; ready to take
//     a point in the first cycle after rst falls.
module least_squares_slope_core #(
  parameter int MAX_POINTS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  lss_pt_if.sink    points,
  lss_res_if.source result
);

  lss_pkg::lss_cmd_t  cmd;
  lss_pkg::lss_stat_t stat;

  // sequencing
  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_ready (points.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // sums, multiplier, divider and result register
  lss_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .x_value     (points.x_value),
    .y_value     (points.y_value),
    .last_point  (points.last_point),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .slope       (result.slope),
    .status      (result.status),
    .point_count (result.point_count)
  );

endmodule

// ===== sv/lss_dp.sv =====
// datapath: sums, shared multiplier, numerator/denominator, divider, result register
`timescale 1ns / 1ps
module lss_dp #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lss_pkg::lss_cmd_t                 cmd,
  output lss_pkg::lss_stat_t                stat,
  input  logic signed [lss_pkg::XW-1:0]     x_value,
  input  logic signed [lss_pkg::XW-1:0]     y_value,
  input  logic                              last_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lss_pkg::SLOPE_W-1:0] slope,
  output logic [1:0]                        status,
  output logic [lss_pkg::CNT_W-1:0]         point_count
);

  localparam logic [lss_pkg::CNT_W-1:0] MAX_CNT = lss_pkg::CNT_W'(MAX_POINTS);

  logic signed [lss_pkg::XW-1:0]     x_r, y_r;
  logic                              last_r;
  logic [lss_pkg::CNT_W-1:0]         count;
  logic signed [lss_pkg::SUM1_W-1:0] sum_x, sum_y;
  logic signed [lss_pkg::SUM2_W-1:0] sum_xy, sum_xx;
  logic                              overflow_seen;
  logic                              pt_en;

  logic signed [lss_pkg::MA_W-1:0]   mul_a;
  logic signed [lss_pkg::MB_W-1:0]   mul_b;
  logic signed [lss_pkg::PROD_W-1:0] prod;
  lss_pkg::lss_mul_op_t              prod_op;
  logic [2:0]                        prod_step;

  logic signed [lss_pkg::ACC_W-1:0]  num, den;
  logic [lss_pkg::ACC_W-1:0]         term;

  logic [lss_pkg::ACC_W-1:0]         mag;
  logic                              sat_pre;
  logic [lss_pkg::ACC_W-1:0]         rem;
  logic [lss_pkg::SLOPE_W-1:0]       qr;
  logic                              neg;
  logic                              sat;
  logic [lss_pkg::ACC_W:0]           rem_sh;
  logic [lss_pkg::ACC_W+1:0]         rem_diff;
  logic                              rem_ge;

  logic signed [lss_pkg::SLOPE_W-1:0] slope_next;
  lss_pkg::lss_status_t              status_next;

  // input beat register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= x_value;
      y_r    <= y_value;
      last_r <= last_point;
    end
  end

  // shared multiplier operand select
  always_comb begin
    logic signed [lss_pkg::SUM2_W-1:0] wsum;
    logic signed [lss_pkg::SUM1_W-1:0] nsum;
    wsum  = cmd.fin_step[2] ? sum_xx : sum_xy;
    nsum  = cmd.fin_step[2] ? sum_x : sum_y;
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      lss_pkg::MUL_XY: begin
        mul_a = {{(lss_pkg::MA_W - lss_pkg::XW){x_r[lss_pkg::XW-1]}}, x_r};
        mul_b = {{(lss_pkg::MB_W - lss_pkg::XW){y_r[lss_pkg::XW-1]}}, y_r};
      end
      lss_pkg::MUL_XX: begin
        mul_a = {{(lss_pkg::MA_W - lss_pkg::XW){x_r[lss_pkg::XW-1]}}, x_r};
        mul_b = {{(lss_pkg::MB_W - lss_pkg::XW){x_r[lss_pkg::XW-1]}}, x_r};
      end
      lss_pkg::MUL_FIN: begin
        unique case (cmd.fin_step[1:0])
          lss_pkg::TERM_N_LO: begin
            mul_a = {1'b0, wsum[35:0]};
            mul_b = {{(lss_pkg::MB_W - lss_pkg::CNT_W){1'b0}}, count};
          end
          lss_pkg::TERM_N_HI: begin
            mul_a = {{13{wsum[59]}}, wsum[59:36]};
            mul_b = {{(lss_pkg::MB_W - lss_pkg::CNT_W){1'b0}}, count};
          end
          lss_pkg::TERM_S_LO: begin
            mul_a = {sum_x[35], sum_x};
            mul_b = {1'b0, nsum[23:0]};
          end
          lss_pkg::TERM_S_HI: begin
            mul_a = {sum_x[35], sum_x};
            mul_b = {{13{nsum[35]}}, nsum[35:24]};
          end
        endcase
      end
      lss_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod      <= mul_a * mul_b;
    prod_step <= cmd.fin_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= lss_pkg::MUL_NONE;
    end else begin
      prod_op <= cmd.mul_op;
    end
  end

  // registered product aligned to its place in the wide result
  always_comb begin
    logic [lss_pkg::ACC_W-1:0] pext;
    pext = {{(lss_pkg::ACC_W - lss_pkg::PROD_W){prod[lss_pkg::PROD_W-1]}}, prod};
    unique case (prod_step[1:0])
      lss_pkg::TERM_N_LO: term = pext;
      lss_pkg::TERM_N_HI: term = pext << 36;
      lss_pkg::TERM_S_LO: term = pext;
      lss_pkg::TERM_S_HI: term = pext << 24;
    endcase
  end

  // running sums
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      count         <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xy        <= '0;
      sum_xx        <= '0;
      overflow_seen <= 1'b0;
      pt_en         <= 1'b0;
    end else begin
      if (cmd.mul_op == lss_pkg::MUL_XY) begin
        if (count < MAX_CNT) begin
          count <= count + 1'b1;
          sum_x <= sum_x + {{(lss_pkg::SUM1_W - lss_pkg::XW){x_r[lss_pkg::XW-1]}}, x_r};
          sum_y <= sum_y + {{(lss_pkg::SUM1_W - lss_pkg::XW){y_r[lss_pkg::XW-1]}}, y_r};
          pt_en <= 1'b1;
        end else begin
          overflow_seen <= 1'b1;
          pt_en         <= 1'b0;
        end
      end
      if (prod_op == lss_pkg::MUL_XY && pt_en) begin
        sum_xy <= sum_xy + prod[lss_pkg::SUM2_W-1:0];
      end
      if (prod_op == lss_pkg::MUL_XX && pt_en) begin
        sum_xx <= sum_xx + prod[lss_pkg::SUM2_W-1:0];
      end
    end
  end

  // numerator and denominator, first term of each loads
  always_ff @(posedge clk) begin
    if (prod_op == lss_pkg::MUL_FIN) begin
      priority case (prod_step[1:0])
        lss_pkg::TERM_N_LO: begin
          if (prod_step[2]) den <= term;
          else num <= term;
        end
        lss_pkg::TERM_N_HI: begin
          if (prod_step[2]) den <= den + term;
          else num <= num + term;
        end
        default: begin
          if (prod_step[2]) den <= den - term;
          else num <= num - term;
        end
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  assign mag      = num[lss_pkg::ACC_W-1] ? lss_pkg::ACC_W'(-num) : num;
  assign sat_pre  = {16'b0, mag} >= {den, 16'b0};
  assign rem_sh   = {rem, qr[lss_pkg::SLOPE_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b0, den};
  assign rem_ge   = ~rem_diff[lss_pkg::ACC_W+1];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= {16'b0, mag[lss_pkg::ACC_W-1:16]};
      qr  <= {mag[15:0], 16'b0};
      neg <= num[lss_pkg::ACC_W-1];
      sat <= sat_pre;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[lss_pkg::ACC_W-1:0] : rem_sh[lss_pkg::ACC_W-1:0];
      qr  <= {qr[lss_pkg::SLOPE_W-2:0], rem_ge};
    end
  end

  // status priority: too many points, zero or negative denominator, saturation
  always_comb begin
    slope_next  = '0;
    status_next = lss_pkg::ST_OK;
    if (overflow_seen) begin
      status_next = lss_pkg::ST_OVERFLOW;
    end else if (den[lss_pkg::ACC_W-1] || den == '0) begin
      status_next = lss_pkg::ST_DEN_ZERO;
    end else if (sat || (neg ? (qr[31] && |qr[30:0]) : qr[31])) begin
      status_next = lss_pkg::ST_SAT;
      slope_next  = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      slope_next  = neg ? lss_pkg::SLOPE_W'(-qr) : qr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slope       <= slope_next;
      status      <= status_next;
      point_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.last     = last_r;
  assign stat.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("point count above limit");
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> count == MAX_CNT)
    else $error("overflow flagged with room left");
  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (count == '0 && !overflow_seen && out_valid))
    else $error("sums not cleared after result load");
`endif

endmodule

// ===== sv/lss_ctrl.sv =====
// controller: point sequencing, final product sequence, divide steps, result load
`timescale 1ns / 1ps
module lss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lss_pkg::lss_stat_t stat,
  output lss_pkg::lss_cmd_t  cmd
);

  lss_pkg::lss_state_t       state, state_next;
  logic [lss_pkg::STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lss_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lss_pkg::S_IDLE: begin
        if (in_valid) state_next = lss_pkg::S_XY;
      end
      lss_pkg::S_XY: state_next = lss_pkg::S_XX;
      lss_pkg::S_XX: begin
        if (stat.last) state_next = lss_pkg::S_MUL;
        else if (in_valid) state_next = lss_pkg::S_XY;
        else state_next = lss_pkg::S_IDLE;
      end
      lss_pkg::S_MUL: begin
        if (cnt[2:0] == lss_pkg::FIN_LAST) state_next = lss_pkg::S_DRAIN;
      end
      lss_pkg::S_DRAIN: state_next = lss_pkg::S_DIV_INIT;
      lss_pkg::S_DIV_INIT: state_next = lss_pkg::S_DIV;
      lss_pkg::S_DIV: begin
        if (cnt == lss_pkg::DIV_LAST) state_next = lss_pkg::S_DONE;
      end
      lss_pkg::S_DONE: begin
        if (stat.out_free) state_next = lss_pkg::S_IDLE;
      end
    endcase
  end

  // step counter runs only while S_MUL or S_DIV repeats
  always_comb begin
    if ((state == lss_pkg::S_MUL || state == lss_pkg::S_DIV) && state_next == state) begin
      cnt_next = cnt + 1'b1;
    end else begin
      cnt_next = '0;
    end
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.mul_op   = lss_pkg::MUL_NONE;
    cmd.fin_step = cnt[2:0];
    cmd.div_init = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      lss_pkg::S_IDLE:     in_ready = 1'b1;
      lss_pkg::S_XY:       cmd.mul_op = lss_pkg::MUL_XY;
      lss_pkg::S_XX: begin
        cmd.mul_op = lss_pkg::MUL_XX;
        in_ready   = !stat.last;
      end
      lss_pkg::S_MUL:      cmd.mul_op = lss_pkg::MUL_FIN;
      lss_pkg::S_DRAIN:    cmd.mul_op = lss_pkg::MUL_NONE;
      lss_pkg::S_DIV_INIT: cmd.div_init = 1'b1;
      lss_pkg::S_DIV:      cmd.div_step = 1'b1;
      lss_pkg::S_DONE:     cmd.load_out = stat.out_free;
    endcase
    cmd.load_in = in_valid && in_ready;
  end

`ifndef SYNTHESIS
  a_fin_after_last_point: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_op == lss_pkg::MUL_FIN && cmd.fin_step == 3'd0)
      |-> $past(cmd.mul_op) == lss_pkg::MUL_XX)
    else $error("final products started without a last point");
`endif

endmodule

// ===== test/tb.sv =====
// testbench for the least-squares slope core: directed table, random sets, scoreboard
`timescale 1ns / 1ps
module tb;

  localparam int MAX_PTS = 4096;
  localparam logic signed [lss_pkg::XW-1:0] X_MIN = 24'h800000;
  localparam logic signed [lss_pkg::XW-1:0] X_MAX = 24'h7FFFFF;
  localparam logic signed [lss_pkg::XW-1:0] Q_ONE = 24'sd65536;   // 1.0 in Q8.16
  localparam int PHASE_POINTS = 250;                       // random points per idling phase
  localparam int HOLD_CYCLES = 600;                        // long result-side hold-off

  // one slope result as it leaves the block
  typedef struct packed {
    logic signed [lss_pkg::SLOPE_W-1:0] slope;
    lss_pkg::lss_status_t               status;
    logic [lss_pkg::CNT_W-1:0]          count;
  } slope_fit_t;

  // one row of the directed table; fit is used only when given is set
  typedef struct {
    logic signed [lss_pkg::XW-1:0] x;
    logic signed [lss_pkg::XW-1:0] y;
    logic                          last;
    bit                            given;
    slope_fit_t                    fit;
  } point_row_t;

  // how a random coordinate is drawn
  typedef enum int {CK_FULL, CK_SMALL, CK_RAIL} coord_kind_t;

  // 128-bit signed work type for the exact numerator and denominator
  typedef logic signed [127:0] wide_t;

  localparam slope_fit_t NO_FIT = '{32'sd0, lss_pkg::ST_OK, 13'd0};

  logic clk;
  logic rst;

  lss_pt_if  pts ();
  lss_res_if res ();

  least_squares_slope_core #(.MAX_POINTS(MAX_PTS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .points (pts),
    .result (res)
  );

  // expected slope results, oldest first
  slope_fit_t fits_due[$];
  int error_count = 0;
  int points_sent = 0;

  // idling controls: sender percentage is only used by the driver itself,
  // receiver percentage and the hold-off request cross to the ready process
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit pressure_go = 1'b0;

  // running sums of the set being collected
  logic [lss_pkg::CNT_W-1:0] set_n;
  longint set_sx, set_sy, set_sxy, set_sxx;
  bit set_dropped;

  // directed table: single point, unit and negative slopes, field extremes,
  // both saturation rails, all x equal, truncation toward zero, bit patterns
  point_row_t dir_rows [23] = '{
    '{Q_ONE, Q_ONE, 1'b1, 1'b1, '{32'sd0, lss_pkg::ST_DEN_ZERO, 13'd1}},
    '{24'sd0, 24'sd0, 1'b0, 1'b0, NO_FIT},
    '{Q_ONE, Q_ONE, 1'b1, 1'b1, '{32'sh10000, lss_pkg::ST_OK, 13'd2}},
    '{24'sd0, 24'sd0, 1'b0, 1'b0, NO_FIT},
    '{Q_ONE, lss_pkg::XW'(-2 * Q_ONE), 1'b1, 1'b1,
      '{-32'sd131072, lss_pkg::ST_OK, 13'd2}},
    '{X_MIN, X_MIN, 1'b0, 1'b0, NO_FIT},
    '{X_MAX, X_MAX, 1'b1, 1'b1, '{32'sh10000, lss_pkg::ST_OK, 13'd2}},
    '{24'sd0, X_MIN, 1'b0, 1'b0, NO_FIT},
    '{24'sd1, X_MAX, 1'b1, 1'b1, '{32'sh7FFFFFFF, lss_pkg::ST_SAT, 13'd2}},
    '{24'sd0, X_MAX, 1'b0, 1'b0, NO_FIT},
    '{24'sd1, X_MIN, 1'b1, 1'b1, '{32'sh80000000, lss_pkg::ST_SAT, 13'd2}},
    '{X_MIN, 24'sd0, 1'b0, 1'b0, NO_FIT},
    '{X_MIN, X_MAX, 1'b1, 1'b1, '{32'sd0, lss_pkg::ST_DEN_ZERO, 13'd2}},
    '{24'sd0, 24'sd0, 1'b0, 1'b0, NO_FIT},
    '{lss_pkg::XW'(3 * Q_ONE), Q_ONE, 1'b1, 1'b0, NO_FIT},
    '{24'sd0, 24'sd0, 1'b0, 1'b0, NO_FIT},
    '{lss_pkg::XW'(3 * Q_ONE), -Q_ONE, 1'b1, 1'b0, NO_FIT},
    '{-24'sd100000, 24'sd50000, 1'b0, 1'b0, NO_FIT},
    '{24'sd3, -24'sd7, 1'b0, 1'b0, NO_FIT},
    '{X_MAX, X_MIN, 1'b1, 1'b0, NO_FIT},
    '{24'h555555, 24'hAAAAAA, 1'b0, 1'b0, NO_FIT},
    '{24'hAAAAAA, 24'h555555, 1'b0, 1'b0, NO_FIT},
    '{24'h000001, 24'hFFFFFF, 1'b1, 1'b0, NO_FIT}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // adds one point to the running sums (or marks the set dropped past MAX_PTS); on the
  // last point of a set it forms the exact slope, fills fit and clears the sums
  function automatic bit fit_point(input logic signed [lss_pkg::XW-1:0] x,
                                   input logic signed [lss_pkg::XW-1:0] y,
                                   input logic last, output slope_fit_t fit);
    longint xl, yl;
    wide_t num, den;
    logic [127:0] mag, quo, cap;
    bit neg;
    xl = x;
    yl = y;
    fit = NO_FIT;
    if (set_n < MAX_PTS) begin
      set_n++;
      set_sx += xl;
      set_sy += yl;
      set_sxy += xl * yl;
      set_sxx += xl * xl;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return 1'b0;

    num = wide_t'(set_n) * wide_t'(set_sxy) - wide_t'(set_sx) * wide_t'(set_sy);
    den = wide_t'(set_n) * wide_t'(set_sxx) - wide_t'(set_sx) * wide_t'(set_sx);
    fit.count = set_n;
    if (set_dropped) begin
      fit.status = lss_pkg::ST_OVERFLOW;
    end else if (den <= 0) begin
      fit.status = lss_pkg::ST_DEN_ZERO;
    end else begin
      // divide magnitudes so the quotient truncates toward zero
      neg = num < 0;
      mag = neg ? -num : num;
      quo = (mag << 16) / den;
      cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (quo > cap) begin
        fit.status = lss_pkg::ST_SAT;
        quo = cap;
      end else begin
        fit.status = lss_pkg::ST_OK;
      end
      fit.slope = neg ? -quo[31:0] : quo[31:0];
    end

    set_n = '0;
    set_sx = 0;
    set_sy = 0;
    set_sxy = 0;
    set_sxx = 0;
    set_dropped = 1'b0;
    return 1'b1;
  endfunction

  // entered and left at a falling edge; drives one point beat and records
  // the result it is expected to cause
  task automatic send_point(input logic signed [lss_pkg::XW-1:0] x,
                            input logic signed [lss_pkg::XW-1:0] y,
                            input logic last, input bit given, input slope_fit_t given_fit);
    slope_fit_t fit;
    while ($urandom_range(99) < src_idle_pct) begin
      pts.valid <= 1'b0;
      @(negedge clk);
    end
    pts.valid      <= 1'b1;
    pts.x_value    <= x;
    pts.y_value    <= y;
    pts.last_point <= last;
    @(posedge clk);
    while (!pts.ready) @(posedge clk);
    if (fit_point(x, y, last, fit)) fits_due = {fits_due, (given ? given_fit : fit)};
    points_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [lss_pkg::XW-1:0] pick_coord(input coord_kind_t kind);
    logic signed [lss_pkg::XW-1:0] v;
    case (kind)
      CK_SMALL: v = lss_pkg::XW'($urandom_range(512) - 256);
      CK_RAIL: begin
        case ($urandom_range(4))
          0: v = X_MIN;
          1: v = X_MAX;
          2: v = 24'sd0;
          3: v = -24'sd1;
          default: v = 24'sd1;
        endcase
      end
      default: v = lss_pkg::XW'($urandom());
    endcase
    return v;
  endfunction

  // mostly short sets, now and then a single point or a longer one
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 1;
    if (r < 70) return $urandom_range(6, 2);
    if (r < 92) return $urandom_range(24, 7);
    return $urandom_range(64, 25);
  endfunction

  // one set of random points; the flavor is chosen once per set
  task automatic send_random_set(input int n);
    int flavor;
    logic signed [lss_pkg::XW-1:0] x_hold, x, y;
    flavor = $urandom_range(99);
    x_hold = pick_coord(CK_FULL);
    for (int i = 0; i < n; i++) begin
      if (flavor < 45) begin
        x = pick_coord(CK_FULL);
        y = pick_coord(CK_FULL);
      end else if (flavor < 70) begin
        x = pick_coord(CK_SMALL);
        y = pick_coord(CK_SMALL);
      end else if (flavor < 85) begin
        // every x the same: the denominator is zero
        x = x_hold;
        y = pick_coord(CK_FULL);
      end else begin
        // rails mixed with full-range values
        x = pick_coord($urandom_range(1) ? CK_RAIL : CK_FULL);
        y = pick_coord($urandom_range(1) ? CK_RAIL : CK_FULL);
      end
      send_point(x, y, i == n - 1, 1'b0, NO_FIT);
    end
  endtask

  // result ready: random stalls, plus one long hold-off so the block backs up
  // and stops taking points
  initial begin
    int hold_left;
    bit pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // result check: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    slope_fit_t want;
    if (!rst && res.valid && res.ready) begin
      if (fits_due.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat, slope %0d status %0d count %0d",
                               res.slope, res.status, res.point_count));
      end else begin
        want = fits_due.pop_front();
        if (res.slope !== want.slope)
          log_mismatch($sformatf("slope got %0d want %0d (set of %0d)",
                                 res.slope, want.slope, want.count));
        if (res.status !== want.status)
          log_mismatch($sformatf("status got %0d want %0d (set of %0d)",
                                 res.status, want.status, want.count));
        if (res.point_count !== want.count)
          log_mismatch($sformatf("point_count got %0d want %0d",
                                 res.point_count, want.count));
      end
    end
  end

  // stimulus
  initial begin
    int phase_start;
    set_n = '0;
    set_sx = 0;
    set_sy = 0;
    set_sxy = 0;
    set_sxx = 0;
    set_dropped = 1'b0;
    pts.valid = 1'b0;
    pts.x_value = '0;
    pts.y_value = '0;
    pts.last_point = 1'b0;

    // reset asserted from time zero and released at a falling edge
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed table, no idling
    foreach (dir_rows[i])
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last, dir_rows[i].given,
                 dir_rows[i].fit);

    // long result hold-off right at the start of the random sets
    pressure_go <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct <= 0;
        end
        1: begin
          src_idle_pct = 78;
          snk_stall_pct <= 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct <= 78;
        end
        default: begin
          src_idle_pct = 12;
          snk_stall_pct <= 12;
        end
      endcase
      phase_start = points_sent;
      while (points_sent - phase_start < PHASE_POINTS) send_random_set(pick_set_size());
    end

    pts.valid <= 1'b0;

    // drain, then wait on for stray beats
    while (fits_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
